FILE: rtl/core/utr_pkg.sv
`default_nettype none
package utr_pkg;

    localparam int POS_W   = 24;
    localparam int HEAD_W  = 16;
    localparam int SPEED_W = 16;
    localparam int RATE_W  = 17;
    localparam int STEP_W  = 6;
    localparam int DT_W    = 13;
    localparam int IDX_W   = 8;
    localparam int DATA_W  = 32;

    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [16:0] SIN_B = 17'd42048;
    localparam logic [16:0] SIN_C = 17'd4640;

    localparam logic signed [POS_W:0] POS_MAX = 25'sd8388607;
    localparam logic signed [POS_W:0] POS_MIN = -25'sd8388608;

    localparam logic [STEP_W-1:0] STEP_COUNT_RST = 6'd60;
    localparam logic [DT_W-1:0]   STEP_TIME_RST  = 13'd3277;

    typedef enum logic [IDX_W-1:0] {
        REG_STEP_COUNT = 8'd0,
        REG_STEP_TIME  = 8'd1
    } reg_idx_t;

endpackage
`default_nettype wire

FILE: rtl/core/utr_if.sv
`default_nettype none
interface utr_traj_if
    import utr_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   start_x;
    logic signed [POS_W-1:0]   start_y;
    logic [HEAD_W-1:0]         start_heading;
    logic signed [SPEED_W-1:0] linear_speed;
    logic signed [RATE_W-1:0]  turn_rate;

    modport source (output valid, start_x, start_y, start_heading, linear_speed, turn_rate,
                    input ready);
    modport sink (input valid, start_x, start_y, start_heading, linear_speed, turn_rate,
                  output ready);
endinterface

interface utr_pose_if
    import utr_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pose_x;
    logic signed [POS_W-1:0] pose_y;
    logic [HEAD_W-1:0]       pose_heading;
    logic [STEP_W-1:0]       step_index;
    logic                    last_pose;

    modport source (output valid, pose_x, pose_y, pose_heading, step_index, last_pose,
                    input ready);
    modport sink (input valid, pose_x, pose_y, pose_heading, step_index, last_pose,
                  output ready);
endinterface

interface utr_cfg_if
    import utr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/unicycle_trajectory_rollout.sv
`default_nettype none
// Throughput: one pose per cycle through an 8-stage sine/product pipeline
// while pose.ready does not stall it; a command of n steps emits n+1 poses
// (k = 0..n), and the next command is taken only once the step sequencer
// has gone idle again.
// Reset: step_count 60, step_time 3277, all valid bits cleared.
module unicycle_trajectory_rollout
    import utr_pkg::*;
#(
    parameter int MAX_STEPS  = 63,
    parameter int ANGLE_BITS = 16
) (
    input  wire       clk,
    input  wire       rst_n,
    utr_traj_if.sink  traj,
    utr_cfg_if.sink   cfg,
    utr_pose_if.source pose
);

    localparam int AB = ANGLE_BITS;
    localparam int FW = AB - 2;
    localparam logic [STEP_W-1:0] MAX_N = STEP_W'(MAX_STEPS);

    typedef struct packed {
        logic                      valid;
        logic [AB-1:0]             th_cur;
        logic [STEP_W-1:0]         k;
        logic                      last;
        logic                      first;
        logic signed [SPEED_W-1:0] v;
        logic signed [POS_W-1:0]   x0;
        logic signed [POS_W-1:0]   y0;
    } meta_t;

    typedef struct packed {
        meta_t                m;
        logic [AB-1:0]        th_prev;
        logic [16:0]          u_c;
        logic [16:0]          u_s;
        logic                 neg_c;
        logic                 neg_s;
        logic [16:0]          z_c;
        logic [16:0]          z_s;
        logic [16:0]          t_c;
        logic [16:0]          t_s;
        logic signed [17:0]   c;
        logic signed [17:0]   s;
        logic signed [33:0]   pc;
        logic signed [33:0]   ps;
    } stage_t;

    function automatic logic [16:0] to_u(input logic [AB-1:0] a);
        logic [FW+15:0] tmp;
        logic [16:0]    u0;
        tmp = {a[FW-1:0], 16'd0};
        u0  = 17'(tmp >> FW);
        return a[AB-2] ? 17'd65536 - u0 : u0;
    endfunction

    function automatic logic signed [POS_W-1:0] clamp(input logic signed [POS_W:0] val);
        if (val > POS_MAX)
            return POS_MAX[POS_W-1:0];
        else if (val < POS_MIN)
            return POS_MIN[POS_W-1:0];
        return val[POS_W-1:0];
    endfunction

    logic [STEP_W-1:0] step_count_reg;
    logic [DT_W-1:0]   step_time_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= STEP_COUNT_RST;
            step_time_reg  <= STEP_TIME_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_STEP_COUNT: step_count_reg <= cfg.data[STEP_W-1:0];
                REG_STEP_TIME:  step_time_reg  <= cfg.data[DT_W-1:0];
                default:        ;
            endcase
        end
    end

    logic                      out_valid_reg;
    logic                      en;
    logic                      busy_reg;
    logic [AB-1:0]             th_reg;
    logic [AB-1:0]             prev_reg;
    logic [AB-1:0]             dth_reg;
    logic [STEP_W-1:0]         k_reg;
    logic [STEP_W-1:0]         n_reg;
    logic signed [SPEED_W-1:0] v_reg;
    logic signed [POS_W-1:0]   x0_reg;
    logic signed [POS_W-1:0]   y0_reg;

    logic signed [30:0]        wdt;
    logic signed [31:0]        wdt_q;
    logic [STEP_W-1:0]         n_next;
    logic [AB-1:0]             th_in;

    assign en         = !out_valid_reg || pose.ready;
    assign traj.ready = !busy_reg;
    assign wdt        = traj.turn_rate * $signed({1'b0, step_time_reg});
    assign wdt_q      = 32'(wdt) + 32'sd32768;
    assign th_in      = AB'(traj.start_heading);

    always_comb
    begin
        n_next = step_count_reg;
        if (n_next == '0)
            n_next = STEP_W'(1);
        if (n_next > MAX_N)
            n_next = MAX_N;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (!busy_reg && traj.valid)
            busy_reg <= 1'b1;
        else if (busy_reg && en && k_reg == n_reg)
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && traj.valid)
        begin
            th_reg   <= th_in;
            prev_reg <= th_in;
            dth_reg  <= AB'(wdt_q >>> 16);
            k_reg    <= '0;
            n_reg    <= n_next;
            v_reg    <= traj.linear_speed;
            x0_reg   <= traj.start_x;
            y0_reg   <= traj.start_y;
        end
        else if (busy_reg && en)
        begin
            k_reg    <= k_reg + STEP_W'(1);
            prev_reg <= th_reg;
            th_reg   <= th_reg + dth_reg;
        end
    end

    stage_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg, s7_reg;
    stage_t s1_next, s2_next, s3_next, s4_next, s5_next, s6_next, s7_next;
    logic [AB-1:0] ang_c;
    logic [33:0]   sq_c, sq_s, zc_c, zc_s, zt_c, zt_s, ur_c, ur_s;
    logic signed [47:0] prod_x, prod_y;

    always_comb
    begin
        s1_next           = '0;
        s1_next.m.valid   = busy_reg;
        s1_next.m.th_cur  = th_reg;
        s1_next.m.k       = k_reg;
        s1_next.m.last    = k_reg == n_reg;
        s1_next.m.first   = k_reg == '0;
        s1_next.m.v       = v_reg;
        s1_next.m.x0      = x0_reg;
        s1_next.m.y0      = y0_reg;
        s1_next.th_prev   = prev_reg;

        s2_next       = s1_reg;
        ang_c         = s1_reg.th_prev + AB'(1 << FW);
        s2_next.u_c   = to_u(ang_c);
        s2_next.u_s   = to_u(s1_reg.th_prev);
        s2_next.neg_c = ang_c[AB-1];
        s2_next.neg_s = s1_reg.th_prev[AB-1];

        s3_next     = s2_reg;
        sq_c        = s2_reg.u_c * s2_reg.u_c;
        sq_s        = s2_reg.u_s * s2_reg.u_s;
        s3_next.z_c = sq_c[32:16];
        s3_next.z_s = sq_s[32:16];

        s4_next     = s3_reg;
        zc_c        = s3_reg.z_c * SIN_C;
        zc_s        = s3_reg.z_s * SIN_C;
        s4_next.t_c = SIN_B - zc_c[32:16];
        s4_next.t_s = SIN_B - zc_s[32:16];

        s5_next     = s4_reg;
        zt_c        = s4_reg.z_c * s4_reg.t_c;
        zt_s        = s4_reg.z_s * s4_reg.t_s;
        s5_next.t_c = SIN_A - zt_c[32:16];
        s5_next.t_s = SIN_A - zt_s[32:16];

        s6_next   = s5_reg;
        ur_c      = s5_reg.u_c * s5_reg.t_c;
        ur_s      = s5_reg.u_s * s5_reg.t_s;
        s6_next.c = s5_reg.neg_c ? -$signed({1'b0, ur_c[32:16]})
                                 : $signed({1'b0, ur_c[32:16]});
        s6_next.s = s5_reg.neg_s ? -$signed({1'b0, ur_s[32:16]})
                                 : $signed({1'b0, ur_s[32:16]});

        s7_next    = s6_reg;
        s7_next.pc = s6_reg.m.v * s6_reg.c;
        s7_next.ps = s6_reg.m.v * s6_reg.s;
    end

    assign prod_x = s7_reg.pc * $signed({1'b0, step_time_reg}) + 48'sd2147483648;
    assign prod_y = s7_reg.ps * $signed({1'b0, step_time_reg}) + 48'sd2147483648;

    logic                    s8_valid_reg;
    meta_t                   s8_meta_reg;
    logic signed [15:0]      dx_reg;
    logic signed [15:0]      dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg       <= '0;
            s2_reg       <= '0;
            s3_reg       <= '0;
            s4_reg       <= '0;
            s5_reg       <= '0;
            s6_reg       <= '0;
            s7_reg       <= '0;
            s8_valid_reg <= 1'b0;
            s8_meta_reg  <= '0;
            dx_reg       <= '0;
            dy_reg       <= '0;
        end
        else if (en)
        begin
            s1_reg       <= s1_next;
            s2_reg       <= s2_next;
            s3_reg       <= s3_next;
            s4_reg       <= s4_next;
            s5_reg       <= s5_next;
            s6_reg       <= s6_next;
            s7_reg       <= s7_next;
            s8_valid_reg <= s7_reg.m.valid;
            s8_meta_reg  <= s7_reg.m;
            dx_reg       <= prod_x[47:32];
            dy_reg       <= prod_y[47:32];
        end
    end

    logic signed [POS_W-1:0] x_reg, y_reg;
    logic [HEAD_W-1:0]       head_reg;
    logic [STEP_W-1:0]       idx_reg;
    logic                    last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= s8_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en && s8_valid_reg)
        begin
            x_reg    <= s8_meta_reg.first ? s8_meta_reg.x0
                                          : clamp((POS_W+1)'(x_reg) + (POS_W+1)'(dx_reg));
            y_reg    <= s8_meta_reg.first ? s8_meta_reg.y0
                                          : clamp((POS_W+1)'(y_reg) + (POS_W+1)'(dy_reg));
            head_reg <= HEAD_W'(s8_meta_reg.th_cur);
            idx_reg  <= s8_meta_reg.k;
            last_reg <= s8_meta_reg.last;
        end
    end

    assign pose.valid        = out_valid_reg;
    assign pose.pose_x       = x_reg;
    assign pose.pose_y       = y_reg;
    assign pose.pose_heading = head_reg;
    assign pose.step_index   = idx_reg;
    assign pose.last_pose    = last_reg;

endmodule
`default_nettype wire
